[src/qs_pkg.sv]
// Shared types and constants for the quicksort engine.
package qs_pkg;

  localparam int DATA_W = 32;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PIV_RD,
    ST_PIV,
    ST_RD_J,
    ST_CMP,
    ST_RD_I,
    ST_SW_J,
    ST_SW_I,
    ST_FIN_RD,
    ST_FIN_LO,
    ST_FIN_I,
    ST_PUSH_L,
    ST_PUSH_R,
    ST_POP,
    ST_POP_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

endpackage

[src/qs_ifs.sv]
// Valid/ready channel interfaces for the input and result items.
interface qs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [qs_pkg::DATA_W-1:0]  value;
  logic                              last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface qs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qs_pkg::DATA_W-1:0]  value_res;
  logic                              last_res;
  logic                              overflow;

  modport source (output valid, output value_res, output last_res, output overflow,
                  input ready);
  modport sink (input valid, input value_res, input last_res, input overflow,
                output ready);
endinterface

[src/qs_stack.sv]
// Stack of pending index ranges with one push or pop per cycle.
module qs_stack #(
  parameter int DEPTH = 33,
  parameter int IW    = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  qs_pkg::stk_ctrl_t ctrl,
  input  logic [IW-1:0]     push_lo,
  input  logic [IW-1:0]     push_hi,
  output logic [IW-1:0]     pop_lo,
  output logic [IW-1:0]     pop_hi,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW = $clog2(DEPTH + 1);

  logic [2*IW-1:0] mem [DEPTH];
  logic [2*IW-1:0] rd_r;
  logic [TW-1:0]   top_r;
  logic [TW-1:0]   top_m1;

  assign top_m1 = top_r - TW'(1);
  assign empty  = (top_r == '0);
  assign pop_lo = rd_r[2*IW-1:IW];
  assign pop_hi = rd_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= '0;
    end else if (ctrl.push) begin
      top_r <= top_r + TW'(1);
    end else if (ctrl.pop) begin
      top_r <= top_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      mem[top_r[AW-1:0]] <= {push_lo, push_hi};
    end
    if (ctrl.pop) begin
      rd_r <= mem[top_m1[AW-1:0]];
    end
  end

endmodule

[src/quicksort_engine.sv]
// Quicksort engine top level: element store, partition sequencer and output register.
//
// Input channel in_ch carries one signed 32-bit value per item plus a last
// mark. Items are stored at one per cycle while the block is idle. Items
// beyond MAX_ITEMS are dropped and the run is flagged as overflowed.
// On the last item the store is sorted in place by quicksort: first element
// of each range is the pivot, smaller values move left. Pending ranges are
// kept on a small stack. All element traffic goes through one store with a
// single write port and one registered read port, so a compare reads then
// tests, a swap reads, writes j and then writes i, and each range is opened,
// closed and popped in states of its own. Each result is then read from the
// store and loaded into the output register.
// in_ch.ready is low from the last item until the final result has been
// loaded into the output register.
// Results leave on out_ch in ascending order, the final one with last_res,
// all with overflow when values were dropped. A stalled receiver holds the
// output register and the sequencer waits; nothing is lost.
// Reset clears the stored count, overflow flag, stack and output valid.
module quicksort_engine #(
  parameter int MAX_ITEMS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  qs_in_if.sink    in_ch,
  qs_out_if.source out_ch
);

  localparam int DW        = qs_pkg::DATA_W;
  localparam int IW        = $clog2(MAX_ITEMS);
  localparam int CW        = $clog2(MAX_ITEMS + 1);
  localparam int STK_DEPTH = MAX_ITEMS / 2 + 1;

  qs_pkg::state_t    state_r, state_nxt;
  qs_pkg::stk_ctrl_t stk_ctrl;

  logic signed [DW-1:0] mem [MAX_ITEMS];
  logic signed [DW-1:0] rd_data_r;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic signed [DW-1:0] mem_wdata;
  logic [IW-1:0]        mem_raddr;

  logic [CW-1:0]        count_r;
  logic                 ovf_r;
  logic [CW-1:0]        k_r;
  logic [IW-1:0]        lo_r, hi_r, i_r, j_r;
  logic signed [DW-1:0] pivot_r;
  logic signed [DW-1:0] vj_r;

  logic                 out_valid_r;
  logic signed [DW-1:0] out_value_r;
  logic                 out_last_r;
  logic                 out_ovf_r;

  logic                 in_acc;
  logic                 full;
  logic [IW-1:0]        first_hi;
  logic                 run_long;
  logic                 less;
  logic                 j_end;
  logic                 push_l_ok, push_r_ok;
  logic [IW-1:0]        push_lo, push_hi;
  logic [IW-1:0]        pop_lo, pop_hi;
  logic                 stk_empty;
  logic                 out_load;
  logic                 emit_last;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign full      = (count_r == CW'(MAX_ITEMS));
  assign first_hi  = full ? IW'(count_r - CW'(1)) : count_r[IW-1:0];
  assign run_long  = full || (count_r != '0);
  assign less      = (rd_data_r < pivot_r);
  assign j_end     = (j_r == hi_r);
  assign push_l_ok = ({1'b0, i_r} > ({1'b0, lo_r} + (IW+1)'(1)));
  assign push_r_ok = (({1'b0, i_r} + (IW+1)'(1)) < {1'b0, hi_r});
  assign emit_last = ((k_r + CW'(1)) == count_r);

  qs_stack #(
    .DEPTH (STK_DEPTH),
    .IW    (IW)
  ) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (stk_ctrl),
    .push_lo (push_lo),
    .push_hi (push_hi),
    .pop_lo  (pop_lo),
    .pop_hi  (pop_hi),
    .empty   (stk_empty)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      qs_pkg::ST_IDLE: begin
        if (in_acc && in_ch.last) begin
          state_nxt = run_long ? qs_pkg::ST_PIV_RD : qs_pkg::ST_EMIT_RD;
        end
      end
      qs_pkg::ST_PIV_RD:   state_nxt = qs_pkg::ST_PIV;
      qs_pkg::ST_PIV:      state_nxt = qs_pkg::ST_RD_J;
      qs_pkg::ST_RD_J:     state_nxt = qs_pkg::ST_CMP;
      qs_pkg::ST_CMP: begin
        if (less) begin
          state_nxt = qs_pkg::ST_RD_I;
        end else begin
          state_nxt = j_end ? qs_pkg::ST_FIN_RD : qs_pkg::ST_RD_J;
        end
      end
      qs_pkg::ST_RD_I:     state_nxt = qs_pkg::ST_SW_J;
      qs_pkg::ST_SW_J:     state_nxt = qs_pkg::ST_SW_I;
      qs_pkg::ST_SW_I:     state_nxt = j_end ? qs_pkg::ST_FIN_RD : qs_pkg::ST_RD_J;
      qs_pkg::ST_FIN_RD:   state_nxt = qs_pkg::ST_FIN_LO;
      qs_pkg::ST_FIN_LO:   state_nxt = qs_pkg::ST_FIN_I;
      qs_pkg::ST_FIN_I:    state_nxt = qs_pkg::ST_PUSH_L;
      qs_pkg::ST_PUSH_L:   state_nxt = qs_pkg::ST_PUSH_R;
      qs_pkg::ST_PUSH_R: begin
        state_nxt = (stk_empty && !push_r_ok) ? qs_pkg::ST_EMIT_RD : qs_pkg::ST_POP;
      end
      qs_pkg::ST_POP:      state_nxt = qs_pkg::ST_POP_WAIT;
      qs_pkg::ST_POP_WAIT: state_nxt = qs_pkg::ST_PIV_RD;
      qs_pkg::ST_EMIT_RD:  state_nxt = qs_pkg::ST_EMIT_LD;
      qs_pkg::ST_EMIT_LD: begin
        if (out_load) begin
          state_nxt = emit_last ? qs_pkg::ST_IDLE : qs_pkg::ST_EMIT_RD;
        end
      end
      default:             state_nxt = qs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = j_r;
    mem_wdata     = rd_data_r;
    mem_raddr     = j_r;
    stk_ctrl.push = 1'b0;
    stk_ctrl.pop  = 1'b0;
    push_lo       = lo_r;
    push_hi       = IW'(i_r - IW'(1));
    out_load      = 1'b0;
    case (state_r)
      qs_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_we      = in_ch.valid && !full;
        mem_waddr   = count_r[IW-1:0];
        mem_wdata   = in_ch.value;
      end
      qs_pkg::ST_PIV_RD: mem_raddr = lo_r;
      qs_pkg::ST_RD_I:   mem_raddr = i_r;
      qs_pkg::ST_SW_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = rd_data_r;
      end
      qs_pkg::ST_SW_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = vj_r;
      end
      qs_pkg::ST_FIN_RD: mem_raddr = i_r;
      qs_pkg::ST_FIN_LO: begin
        mem_we    = 1'b1;
        mem_waddr = lo_r;
        mem_wdata = rd_data_r;
      end
      qs_pkg::ST_FIN_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = pivot_r;
      end
      qs_pkg::ST_PUSH_L: begin
        stk_ctrl.push = push_l_ok;
      end
      qs_pkg::ST_PUSH_R: begin
        stk_ctrl.push = push_r_ok;
        push_lo       = IW'(i_r + IW'(1));
        push_hi       = hi_r;
      end
      qs_pkg::ST_POP:     stk_ctrl.pop = 1'b1;
      qs_pkg::ST_EMIT_RD: mem_raddr = k_r[IW-1:0];
      qs_pkg::ST_EMIT_LD: begin
        mem_raddr = k_r[IW-1:0];
        out_load  = !out_valid_r || out_ch.ready;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qs_pkg::ST_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == qs_pkg::ST_IDLE && in_acc) begin
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          count_r <= count_r + CW'(1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (emit_last) begin
          k_r     <= '0;
          count_r <= '0;
          ovf_r   <= 1'b0;
        end else begin
          k_r <= k_r + CW'(1);
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      qs_pkg::ST_IDLE: begin
        lo_r <= '0;
        hi_r <= first_hi;
      end
      qs_pkg::ST_PIV: begin
        pivot_r <= rd_data_r;
        i_r     <= lo_r;
        j_r     <= IW'(lo_r + IW'(1));
      end
      qs_pkg::ST_CMP: begin
        vj_r <= rd_data_r;
        if (less) begin
          i_r <= IW'(i_r + IW'(1));
        end else if (!j_end) begin
          j_r <= IW'(j_r + IW'(1));
        end
      end
      qs_pkg::ST_SW_I: begin
        if (!j_end) begin
          j_r <= IW'(j_r + IW'(1));
        end
      end
      qs_pkg::ST_POP_WAIT: begin
        lo_r <= pop_lo;
        hi_r <= pop_hi;
      end
      default: begin
        pivot_r <= pivot_r;
      end
    endcase
    if (out_load) begin
      out_value_r <= rd_data_r;
      out_last_r  <= emit_last;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.value_res = out_value_r;
  assign out_ch.last_res  = out_last_r;
  assign out_ch.overflow  = out_ovf_r;

  a_range_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qs_pkg::ST_PIV_RD) |-> (lo_r < hi_r))
    else $error("partition started on a range shorter than two");

  a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == qs_pkg::ST_CMP) |-> ((i_r < j_r) && (j_r <= hi_r) && (lo_r <= i_r)))
    else $error("partition indexes out of order");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("element count beyond capacity");

  a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && emit_last) |=> ((count_r == '0) && !ovf_r && (state_r == qs_pkg::ST_IDLE)))
    else $error("run state not cleared after final result");

endmodule
